@@ src/shk_pkg.sv @@
// Shared types and constants for the descending shaker sort block.
package shk_pkg;

  // Default configuration of the block.
  localparam int SHK_DEPTH         = 32;
  localparam int SHK_ELEMENT_WIDTH = 16;

  // Width of the value fields on the ports.
  localparam int VALUE_WIDTH = 16;

  // One input request.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
  } in_req_t;

  // One result request.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value_res;
    logic                          last_res;
    logic                          overflow;
  } out_res_t;

  // Control from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic last;
    logic overflow;
  } emit_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FWD_FIRST,
    ST_FWD_STEP,
    ST_FWD_END,
    ST_BWD_STEP,
    ST_BWD_END,
    ST_EMIT_RD,
    ST_EMIT_WR
  } shk_state_t;

endpackage

@@ src/shk_mem.sv @@
// Element store: one write port and one read port with registered read data.
module shk_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/shk_seq.sv @@
// Sequencer: loads elements, runs the shaker sort passes on the store, then reads it out.
module shk_seq #(
  parameter int DEPTH         = 32,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic                     in_last,
  input  logic [ELEMENT_WIDTH-1:0] in_elem,
  input  logic                     out_free,
  output logic                     in_stall,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [ELEMENT_WIDTH-1:0] mem_rdata,
  output shk_pkg::emit_t           emit
);
  import shk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  shk_state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [AW-1:0]            left_r, left_nxt;
  logic [AW-1:0]            right_r, right_nxt;
  logic                     swap_r, swap_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            emit_idx_r, emit_idx_nxt;
  logic [ELEMENT_WIDTH-1:0] carry_r, carry_nxt;
  logic [ELEMENT_WIDTH-1:0] hold_r, hold_nxt;

  logic          round_go;
  logic [AW-1:0] idx_inc;
  logic [AW-1:0] idx_dec;
  logic [AW-1:0] right_dec;
  logic [CW-1:0] count_after;
  logic          store_full;
  logic          emit_last;
  logic          fwd_swap;
  logic          bwd_swap;

  // Shared conditions and index arithmetic.
  assign round_go    = (left_r < right_r) && swap_r;
  assign idx_inc     = idx_r + AW'(1);
  assign idx_dec     = idx_r - AW'(1);
  assign right_dec   = right_r - AW'(1);
  assign store_full  = (count_r >= CW'(DEPTH));
  assign count_after = store_full ? count_r : count_r + CW'(1);
  assign emit_last   = (CW'(emit_idx_r) + CW'(1)) == count_r;
  assign fwd_swap    = $signed(carry_r) < $signed(mem_rdata);
  assign bwd_swap    = $signed(mem_rdata) < $signed(carry_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = round_go ? ST_FWD_FIRST : ST_EMIT_RD;
      end
      ST_FWD_FIRST: begin
        state_nxt = ST_FWD_STEP;
      end
      ST_FWD_STEP: begin
        if (!(idx_inc < right_r)) begin
          state_nxt = ST_FWD_END;
        end
      end
      ST_FWD_END: begin
        state_nxt = (right_dec > left_r) ? ST_BWD_STEP : ST_ROUND;
      end
      ST_BWD_STEP: begin
        if (!(idx_dec > left_r)) begin
          state_nxt = ST_BWD_END;
        end
      end
      ST_BWD_END: begin
        state_nxt = ST_ROUND;
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: begin
        state_nxt = emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Outputs, store accesses and datapath updates.
  always_comb begin
    in_stall      = (state_r != ST_LOAD);
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = carry_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    emit          = '0;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    swap_nxt      = swap_r;
    idx_nxt       = idx_r;
    emit_idx_nxt  = emit_idx_r;
    carry_nxt     = carry_r;
    hold_nxt      = hold_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (store_full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            mem_wdata = in_elem;
            count_nxt = count_after;
          end
          if (in_last) begin
            left_nxt     = '0;
            right_nxt    = AW'(count_after - CW'(1));
            swap_nxt     = 1'b1;
            emit_idx_nxt = '0;
          end
        end
      end
      ST_ROUND: begin
        if (round_go) begin
          swap_nxt  = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = left_r;
        end
      end
      ST_FWD_FIRST: begin
        carry_nxt = mem_rdata;
        idx_nxt   = left_r;
        mem_re    = 1'b1;
        mem_raddr = left_r + AW'(1);
      end
      // Forward step: the larger value stays at idx, the smaller moves on.
      ST_FWD_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = fwd_swap ? mem_rdata : carry_r;
        carry_nxt = fwd_swap ? carry_r : mem_rdata;
        hold_nxt  = fwd_swap ? mem_rdata : carry_r;
        if (fwd_swap) begin
          swap_nxt = 1'b1;
        end
        idx_nxt   = idx_inc;
        mem_re    = 1'b1;
        mem_raddr = idx_r + AW'(2);
      end
      // End of the forward pass: park the smallest value at the right bound.
      ST_FWD_END: begin
        mem_we    = 1'b1;
        mem_waddr = right_r;
        mem_wdata = carry_r;
        right_nxt = right_dec;
        if (right_dec > left_r) begin
          carry_nxt = hold_r;
          idx_nxt   = right_dec;
          mem_re    = 1'b1;
          mem_raddr = right_dec - AW'(1);
        end else begin
          left_nxt = left_r + AW'(1);
        end
      end
      // Backward step: the smaller value stays at idx, the larger moves down.
      ST_BWD_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = bwd_swap ? mem_rdata : carry_r;
        carry_nxt = bwd_swap ? carry_r : mem_rdata;
        if (bwd_swap) begin
          swap_nxt = 1'b1;
        end
        idx_nxt   = idx_dec;
        mem_re    = 1'b1;
        mem_raddr = idx_r - AW'(2);
      end
      ST_BWD_END: begin
        mem_we    = 1'b1;
        mem_waddr = left_r;
        mem_wdata = carry_r;
        left_nxt  = left_r + AW'(1);
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          mem_re    = 1'b1;
          mem_raddr = emit_idx_r;
        end
      end
      ST_EMIT_WR: begin
        emit.load     = 1'b1;
        emit.last     = emit_last;
        emit.overflow = ovf_r;
        emit_idx_nxt  = emit_idx_r + AW'(1);
        if (emit_last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      left_r  <= '0;
      right_r <= '0;
      swap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      swap_r  <= swap_nxt;
    end
  end

  // Working registers of the passes and the readout.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    emit_idx_r <= emit_idx_nxt;
    carry_r    <= carry_nxt;
    hold_r     <= hold_nxt;
  end

endmodule

@@ src/shaker_sort_descending_unit.sv @@
// Top level of the descending shaker sort block: store, sequencer and result register.
//
//   channel | direction | payload    | handshake
//   in_     | input     | in_req_t   | in_valid / in_stall
//   out_    | output    | out_res_t  | out_valid / out_stall
//
// Loading accepts one request per cycle. After the request marked last, the sort
// runs rounds of a forward pass and, while the bounds allow, a backward pass,
// limited by the single read port of the element store. Readout reads each result
// from the store once the output register is free, then loads it into that register.
// Reset is synchronous and needs no clearing pass; input stalls from the last
// request until the final result sits in the output register.
module shaker_sort_descending_unit #(
  parameter int DEPTH         = shk_pkg::SHK_DEPTH,
  parameter int ELEMENT_WIDTH = shk_pkg::SHK_ELEMENT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  shk_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output shk_pkg::out_res_t out_data
);
  import shk_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                     in_fire;
  logic                     out_free;
  logic [ELEMENT_WIDTH-1:0] in_elem;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  emit_t                    emit;
  logic                     out_valid_r, out_valid_nxt;
  out_res_t                 out_data_r, out_data_nxt;

  // Input request handshake and conversion to the stored element width.
  assign in_fire = in_valid && !in_stall;
  assign in_elem = ELEMENT_WIDTH'($unsigned(in_data.value));

  shk_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  shk_seq #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_data.last),
    .in_elem   (in_elem),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .emit      (emit)
  );

  // Result register: loaded from the store, held while the output stalls.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (emit.load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.value_res = VALUE_WIDTH'($signed(mem_rdata));
      out_data_nxt.last_res  = emit.last;
      out_data_nxt.overflow  = emit.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/shk_check.sv @@
// Port-level checks of the descending shaker sort block, bound to its top level.
module shk_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input shk_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input shk_pkg::out_res_t out_data
);
  import shk_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Loading continues after a request that is not marked last.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last |=> !in_stall)
    else $error("input stalled in the middle of loading");

  // The request marked last starts the sort, which blocks the input.
  a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input not stalled after the final request");

  // While the burst is not finished, no new run may load.
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_res |-> in_stall)
    else $error("input open during a result burst");

endmodule

bind shaker_sort_descending_unit shk_check u_shk_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
